>>> sv/fqs_pkg.sv
// fqs_pkg: shared types, constants and ring index helper for the
// search queue. Depends on nothing; used by fqs_store and the core.
package fqs_pkg;

    localparam int DEPTH  = 32;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] word_t;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_SHOW   = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // store port request from the sequencer
    typedef struct packed {
        logic  wr_en;
        ptr_t  wr_addr;
        word_t wr_data;
        logic  rd_en;
        ptr_t  rd_addr;
    } store_req_t;

    // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
    function automatic ptr_t ring_pos(input ptr_t base, input cnt_t off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

>>> sv/fqs_store.sv
// fqs_store: ring entry memory, one write and one registered read per cycle.
// Depends on fqs_pkg.
module fqs_store (
    input  logic               aclk,
    input  fqs_pkg::store_req_t req,
    output fqs_pkg::word_t     rd_data
);
    import fqs_pkg::*;

    word_t mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/fifo_queue_with_search_core.sv
// fifo_queue_with_search_core: bounded FIFO of signed words with search and
// show, run by a small sequencer over one ring store. Depends on fqs_pkg, fqs_store.
//
//   channel | ports                            | dir
//   request | s_valid s_ready s_cmd s_value    | in
//   result  | m_valid m_ready m_status m_data m_last | out
//
// Sequence per request: insert, and any command on an empty queue, go from
// idle straight to the result. Delete reads the head, then gives the result. Search reads
// entries from the head until a hit or the last entry, one store entry compared per cycle
// through the single read port. Show reads and gives one listed entry at a time, tail first.
// Each result is held until m_ready takes it; s_ready is low until the last
// result is taken. aresetn (synchronous, active low) empties the queue; store contents persist.
module fifo_queue_with_search_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic signed [31:0]         s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_status,
    output logic signed [31:0]         m_data,
    output logic                       m_last
);
    import fqs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    ptr_t       head_reg, head_next;
    cnt_t       count_reg, count_next;
    cnt_t       idx_reg, idx_next;
    logic [1:0] op_reg, op_next;
    word_t      key_reg, key_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_status_reg, m_status_next;
    word_t      m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;

    store_req_t req;
    word_t      rd_data;

    fqs_store u_store (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        req           = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_cmd;
                    key_next      = s_value;
                    m_data_next   = '0;
                    m_last_next   = 1'b1;
                    m_status_next = ST_EMPTY;
                    unique case (s_cmd)
                        CMD_INSERT: begin
                            m_valid_next = 1'b1;
                            state_next   = S_OUT;
                            if (count_reg == cnt_t'(DEPTH)) begin
                                m_status_next = ST_FULL;
                            end else begin
                                req.wr_en     = 1'b1;
                                req.wr_addr   = ring_pos(head_reg, count_reg);
                                req.wr_data   = s_value;
                                count_next    = count_reg + cnt_t'(1);
                                m_status_next = ST_DONE;
                            end
                        end
                        CMD_DELETE, CMD_SEARCH: begin
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                state_next   = S_OUT;
                            end else begin
                                idx_next    = '0;
                                req.rd_en   = 1'b1;
                                req.rd_addr = head_reg;
                                state_next  = S_READ;
                            end
                        end
                        CMD_SHOW: begin
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                state_next   = S_OUT;
                            end else begin
                                idx_next    = count_reg - cnt_t'(1);
                                req.rd_en   = 1'b1;
                                req.rd_addr = ring_pos(head_reg, count_reg - cnt_t'(1));
                                state_next  = S_READ;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                m_data_next = '0;
                m_last_next = 1'b1;
                unique case (op_reg)
                    CMD_DELETE: begin
                        m_status_next = ST_DONE;
                        m_data_next   = rd_data;
                        head_next     = ring_pos(head_reg, cnt_t'(1));
                        count_next    = count_reg - cnt_t'(1);
                        m_valid_next  = 1'b1;
                        state_next    = S_OUT;
                    end
                    CMD_SEARCH: begin
                        if (rd_data == key_reg) begin
                            m_status_next = ST_FOUND;
                            m_valid_next  = 1'b1;
                            state_next    = S_OUT;
                        end else if (idx_reg + cnt_t'(1) == count_reg) begin
                            m_status_next = ST_NOT_FOUND;
                            m_valid_next  = 1'b1;
                            state_next    = S_OUT;
                        end else begin
                            idx_next    = idx_reg + cnt_t'(1);
                            req.rd_en   = 1'b1;
                            req.rd_addr = ring_pos(head_reg, idx_reg + cnt_t'(1));
                        end
                    end
                    CMD_SHOW: begin
                        m_status_next = ST_DONE;
                        m_data_next   = rd_data;
                        m_last_next   = (idx_reg == '0);
                        m_valid_next  = 1'b1;
                        state_next    = S_OUT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (op_reg == CMD_SHOW && !m_last_reg) begin
                        idx_next    = idx_reg - cnt_t'(1);
                        req.rd_en   = 1'b1;
                        req.rd_addr = ring_pos(head_reg, idx_reg - cnt_t'(1));
                        state_next  = S_READ;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_last   = m_last_reg;

endmodule

>>> tb/fqs_queue_checker.sv
// fqs_queue_checker: watches both channels of the search queue, keeps its own
// copy of the ring store and compares every result with the predicted one.
// Depends on fqs_pkg; instantiated beside the core by tb_fifo_queue_with_search_core.
`timescale 1ns / 1ps

module fqs_queue_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_status,
    input  logic signed [31:0] m_data,
    input  logic               m_last,
    output int                 err_count,
    output int                 results_due,
    output int                 results_checked
);
    import fqs_pkg::*;

    typedef struct packed {
        logic [2:0] status;
        word_t      data;
        logic       last;
    } outcome_t;

    word_t    q_store [DEPTH];
    int       q_head;
    int       q_count;
    outcome_t pending_results [$];
    int       errs;
    int       n_checked;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errs++;
    endtask

    function automatic void add_due(input logic [2:0] st, input word_t d, input logic l);
        outcome_t o;
        o.status = st;
        o.data   = d;
        o.last   = l;
        pending_results.push_back(o);
    endfunction

    task automatic apply_queue_cmd(input logic [1:0] cmd, input word_t key);
        int k;
        bit hit;
        hit = 1'b0;
        case (cmd)
            CMD_INSERT: begin
                if (q_count >= DEPTH) begin
                    add_due(ST_FULL, '0, 1'b1);
                end else begin
                    q_store[(q_head + q_count) % DEPTH] = key;
                    q_count++;
                    add_due(ST_DONE, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (q_count == 0) begin
                    add_due(ST_EMPTY, '0, 1'b1);
                end else begin
                    add_due(ST_DONE, q_store[q_head], 1'b1);
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                end
            end
            CMD_SEARCH: begin
                if (q_count == 0) begin
                    add_due(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (k = 0; k < q_count; k++) begin
                        if (q_store[(q_head + k) % DEPTH] == key) begin
                            hit = 1'b1;
                        end
                    end
                    add_due(hit ? ST_FOUND : ST_NOT_FOUND, '0, 1'b1);
                end
            end
            CMD_SHOW: begin
                if (q_count == 0) begin
                    add_due(ST_EMPTY, '0, 1'b1);
                end else begin
                    // tail first, last flag on the head entry
                    for (k = q_count - 1; k >= 0; k--) begin
                        add_due(ST_DONE, q_store[(q_head + k) % DEPTH], k == 0);
                    end
                end
            end
        endcase
    endtask

    task automatic check_result(input logic [2:0] st, input word_t d, input logic l);
        outcome_t want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing due: status %0d data %h last %0b",
                                      st, d, l));
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        if (st !== want.status || d !== want.data || l !== want.last) begin
            report_mismatch($sformatf("got status %0d data %h last %0b, want %0d %h %0b",
                                      st, d, l, want.status, want.data, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            q_head  = 0;
            q_count = 0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_status, m_data, m_last);
            end
            if (s_valid && s_ready) begin
                apply_queue_cmd(s_cmd, s_value);
            end
        end
        results_due     <= pending_results.size();
        err_count       <= errs;
        results_checked <= n_checked;
    end

endmodule

>>> tb/tb_fifo_queue_with_search_core.sv
// tb_fifo_queue_with_search_core: drives requests into the search queue core
// with random gaps and result stalls, and gives the verdict from the checker.
// Depends on fqs_pkg, fifo_queue_with_search_core and fqs_queue_checker.
`timescale 1ns / 1ps

module tb_fifo_queue_with_search_core;
    import fqs_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 600000;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd   = CMD_INSERT;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_status;
    logic signed [31:0] m_data;
    logic               m_last;

    int    err_count;
    int    results_due;
    int    results_checked;
    int    cycles = 0;
    int    n_sent [4];
    bit    quiet     = 1'b0;
    bit    hold_req  = 1'b0;
    bit    hold_done = 1'b0;
    word_t inserted_vals [$];
    word_t last_inserted;

    fifo_queue_with_search_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_data   (m_data),
        .m_last   (m_last)
    );

    fqs_queue_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_data          (m_data),
        .m_last          (m_last),
        .err_count       (err_count),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic word_t pick_value(input int pool_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < pool_pct && inserted_vals.size() > 0) begin
            return inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
        end
        if (r < pool_pct + 12) begin
            case ($urandom_range(0, 4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h0000_0001;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_request(input logic [1:0] cmd, input word_t val);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        n_sent[cmd]++;
        if (cmd == CMD_INSERT) begin
            last_inserted = val;
            inserted_vals.push_back(val);
            if (inserted_vals.size() > 48) begin
                void'(inserted_vals.pop_front());
            end
        end
    endtask

    task automatic mixed_requests(input int n);
        int i;
        int r;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_request(CMD_INSERT, pick_value(30));
            end else if (r < 65) begin
                send_request(CMD_DELETE, $urandom);
            end else if (r < 90) begin
                send_request(CMD_SEARCH, pick_value(70));
            end else begin
                send_request(CMD_SHOW, $urandom);
            end
        end
    endtask

    // result side: random stalls, one long hold on request, none when quiet
    initial begin
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin
        n_sent = '{default: 0};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty queue, extremes, hit and miss, show, delete
        send_request(CMD_DELETE, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 32'h0000_0000);
        send_request(CMD_SHOW,   32'h8000_0000);
        send_request(CMD_INSERT, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_SEARCH, 32'h8000_0000);
        send_request(CMD_SEARCH, 32'h0000_0001);
        send_request(CMD_SHOW,   32'h7FFF_FFFF);
        send_request(CMD_DELETE, 32'h0000_0000);
        send_request(CMD_SEARCH, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 32'hAAAA_AAAA);
        send_request(CMD_INSERT, 32'h5555_5555);
        send_request(CMD_SHOW,   32'h0000_0000);
        send_request(CMD_SEARCH, 32'h5555_5555);

        mixed_requests(15);

        // fill past full, then a full-depth show under a long result stall
        repeat (34) send_request(CMD_INSERT, pick_value(10));
        hold_req = 1'b1;
        send_request(CMD_SHOW, $urandom);
        send_request(CMD_SEARCH, last_inserted);
        send_request(CMD_SEARCH, $urandom);

        // drain past empty; head wraps around the ring
        repeat (34) send_request(CMD_DELETE, $urandom);
        mixed_requests(10);

        quiet = 1'b1;
        mixed_requests(20);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("covered %0d requests: insert %0d, delete %0d, search %0d, show %0d",
                 n_sent[0] + n_sent[1] + n_sent[2] + n_sent[3],
                 n_sent[CMD_INSERT], n_sent[CMD_DELETE], n_sent[CMD_SEARCH], n_sent[CMD_SHOW]);
        $display("%0d results checked across empty, full, ring wrap and a %0d-cycle stall",
                 results_checked, HOLD_CYCLES);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
sv/fqs_pkg.sv
sv/fqs_store.sv
sv/fifo_queue_with_search_core.sv
tb/fqs_queue_checker.sv
tb/tb_fifo_queue_with_search_core.sv
